// File: hw/rtl/calibrated_sensor_linearizer_defines.svh
// ----------------------------------------------------------------------------
// Sensor linearizer assertion macros
// Shared assertion shorthands, clocked on i_clk and gated by reset.
// ----------------------------------------------------------------------------
`ifndef CALIBRATED_SENSOR_LINEARIZER_DEFINES_SVH
`define CALIBRATED_SENSOR_LINEARIZER_DEFINES_SVH

// check a condition on every clock out of reset
`define CSL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// check that a condition implies another in the same cycle
`define CSL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/csl_pkg.sv
// ----------------------------------------------------------------------------
// Sensor linearizer package
// Shared types, register codes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package csl_pkg;

    localparam int TABLE_DEPTH_DEF  = 16;
    localparam int READING_BITS_DEF = 20;
    localparam int QUEUE_DEPTH      = 4;
    localparam int FULL_SCALE_X100  = 10000;

    localparam logic [15:0] MIN_CURRENT_RST  = 16'd4000;
    localparam logic [15:0] MAX_CURRENT_RST  = 16'd20000;
    localparam logic [15:0] STEP_CURRENT_RST = 16'd1600;

    localparam logic [1:0] CFG_MIN_CURRENT  = 2'd0;
    localparam logic [1:0] CFG_MAX_CURRENT  = 2'd1;
    localparam logic [1:0] CFG_STEP_CURRENT = 2'd2;

    localparam logic CMD_PROCESS = 1'b0;
    localparam logic CMD_STORE   = 1'b1;

    typedef struct packed {
        logic [15:0] min_ua;
        logic [15:0] max_ua;
        logic [15:0] step_ua;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE, S_SREQ, S_SCMP, S_X1, S_X2, S_DIFF, S_PROD, S_DIST, S_DISTW,
        S_CURQ, S_CURW, S_CLAMP, S_PMUL, S_PER, S_PERW, S_OUT
    } t_bstate;

endpackage
`default_nettype wire

// File: hw/rtl/calibrated_sensor_linearizer.sv
// ----------------------------------------------------------------------------
// Calibrated sensor linearizer
// Linearizes sensor words through a stored descending calibration table.
//
//   channel   handshake          payload
//   input     i_valid / o_stall  i_cmd, i_raw_word, i_cal_index
//   output    o_valid / i_stall  o_reading .. o_percent_x100
//   config    i_cfg_we           i_cfg_idx, i_cfg_data
//
// A store is written to the table from the idle state, which the back end
// does not leave for it. A conversion searches the table over the single
// table read port, then runs up to three serial divisions in one divider.
// A four-entry queue lets the front accept during back-end work.
// Reset is synchronous; the table is undefined until stored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "calibrated_sensor_linearizer_defines.svh"
module calibrated_sensor_linearizer #(
    parameter int TABLE_DEPTH  = csl_pkg::TABLE_DEPTH_DEF,
    parameter int READING_BITS = csl_pkg::READING_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic                    i_cmd,
    input  wire logic [31:0]             i_raw_word,
    input  wire logic [3:0]              i_cal_index,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [READING_BITS-1:0]      o_reading,
    output logic                         o_data_error,
    output logic [3:0]                   o_segment_index,
    output logic signed [15:0]           o_distance_q8,
    output logic [15:0]                  o_current_ua,
    output logic [13:0]                  o_percent_x100,
    input  wire logic                    i_cfg_we,
    input  wire logic [1:0]              i_cfg_idx,
    input  wire logic [15:0]             i_cfg_data
);
    import csl_pkg::*;

    localparam int ITEM_W = READING_BITS + 6;

    t_cfg              w_cfg;
    logic              w_push;
    logic              w_pop;
    logic              w_full;
    logic              w_empty;
    logic [ITEM_W-1:0] w_in_item;
    logic [ITEM_W-1:0] w_q_item;

    csl_front #(.READING_BITS(READING_BITS), .ITEM_W(ITEM_W)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_raw_word  (i_raw_word),
        .i_cal_index (i_cal_index),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_item      (w_in_item)
    );

    csl_fifo #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_in_item),
        .i_pop   (w_pop),
        .o_data  (w_q_item),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    csl_back #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .READING_BITS (READING_BITS),
        .ITEM_W       (ITEM_W)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_empty         (w_empty),
        .i_item          (w_q_item),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_reading       (o_reading),
        .o_data_error    (o_data_error),
        .o_segment_index (o_segment_index),
        .o_distance_q8   (o_distance_q8),
        .o_current_ua    (o_current_ua),
        .o_percent_x100  (o_percent_x100)
    );

    `CSL_ASSERT_IMPL(a_no_push_full, w_push, !w_full, "queue push while full")
    `CSL_ASSERT_IMPL(a_no_pop_empty, w_pop, !w_empty, "queue pop while empty")
    `CSL_ASSERT_IMPL(a_per_range, o_valid, o_percent_x100 <= 14'd10000, "percent out of range")

endmodule
`default_nettype wire

// File: hw/rtl/csl_front.sv
// ----------------------------------------------------------------------------
// Sensor linearizer front end
// Accepts commands, extracts the reading, holds configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module csl_front #(
    parameter int READING_BITS = csl_pkg::READING_BITS_DEF,
    parameter int ITEM_W       = READING_BITS + 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic                i_cmd,
    input  wire logic [31:0]         i_raw_word,
    input  wire logic [3:0]          i_cal_index,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_idx,
    input  wire logic [15:0]         i_cfg_data,
    output csl_pkg::t_cfg            o_cfg,
    input  wire logic                i_full,
    output logic                     o_push,
    output logic [ITEM_W-1:0]        o_item
);
    import csl_pkg::*;

    logic [READING_BITS-1:0] r_last;
    logic [READING_BITS-1:0] w_new;
    logic [READING_BITS-1:0] w_use;
    logic                    w_err;
    t_cfg                    r_cfg;

    assign w_err   = |i_raw_word[31:28];
    assign w_new   = i_raw_word[27 -: READING_BITS];
    assign w_use   = (i_cmd == CMD_PROCESS && !w_err) ? w_new : r_last;
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;
    assign o_item  = {i_cmd, w_err && (i_cmd == CMD_PROCESS), i_cal_index, w_use};
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last        <= '0;
            r_cfg.min_ua  <= MIN_CURRENT_RST;
            r_cfg.max_ua  <= MAX_CURRENT_RST;
            r_cfg.step_ua <= STEP_CURRENT_RST;
        end else begin
            if (o_push && i_cmd == CMD_PROCESS && !w_err) begin
                r_last <= w_new;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MIN_CURRENT:  r_cfg.min_ua  <= i_cfg_data;
                    CFG_MAX_CURRENT:  r_cfg.max_ua  <= i_cfg_data;
                    CFG_STEP_CURRENT: r_cfg.step_ua <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/csl_fifo.sv
// ----------------------------------------------------------------------------
// Sensor linearizer command queue
// Small register queue between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module csl_fifo #(
    parameter int WIDTH = 26,
    parameter int DEPTH = csl_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_full,
    output logic                  o_empty
);
    import csl_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;

    assign o_data  = r_mem[r_rptr];
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/csl_div.sv
// ----------------------------------------------------------------------------
// Sensor linearizer divider
// Signed division rounded half away from zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module csl_div #(
    parameter int NUM_W = 38,
    parameter int DEN_W = 21
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [NUM_W-1:0] i_num,
    input  wire logic signed [DEN_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [NUM_W+1:0] o_quo
);
    import csl_pkg::*;

    localparam int A_W   = NUM_W + 1;
    localparam int CNT_W = $clog2(A_W + 1);

    logic [NUM_W-1:0]      w_un;
    logic [DEN_W-1:0]      w_ud;
    logic [A_W-1:0]        r_a;
    logic [DEN_W-1:0]      r_d;
    logic [DEN_W-1:0]      r_rem;
    logic                  r_neg;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_done;
    logic [DEN_W:0]        w_trial;
    logic                  w_ge;
    logic signed [A_W:0]   w_q;

    assign w_un    = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign w_ud    = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
    assign w_trial = {r_rem, r_a[A_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_d});
    assign w_q     = $signed({1'b0, r_a});
    assign o_quo   = r_neg ? -w_q : w_q;
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= A_W'(w_un) + A_W'(w_ud >> 1);
            r_d   <= w_ud;
            r_rem <= '0;
            r_neg <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
        end else if (r_cnt != '0) begin
            r_a   <= {r_a[A_W-2:0], w_ge};
            r_rem <= w_ge ? DEN_W'(w_trial - {1'b0, r_d}) : DEN_W'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(A_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/csl_back.sv
// ----------------------------------------------------------------------------
// Sensor linearizer back end
// Table store, segment search, interpolation and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module csl_back #(
    parameter int TABLE_DEPTH  = csl_pkg::TABLE_DEPTH_DEF,
    parameter int READING_BITS = csl_pkg::READING_BITS_DEF,
    parameter int ITEM_W       = READING_BITS + 6
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  csl_pkg::t_cfg                i_cfg,
    input  wire logic                    i_empty,
    input  wire logic [ITEM_W-1:0]       i_item,
    output logic                         o_pop,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [READING_BITS-1:0]      o_reading,
    output logic                         o_data_error,
    output logic [3:0]                   o_segment_index,
    output logic signed [15:0]           o_distance_q8,
    output logic [15:0]                  o_current_ua,
    output logic [13:0]                  o_percent_x100
);
    import csl_pkg::*;

    localparam int R      = READING_BITS;
    localparam int SEG_W  = $clog2(TABLE_DEPTH);
    localparam int PROD_W = R + 18;
    localparam int DVN_W  = (PROD_W > 32) ? PROD_W : 32;
    localparam int DEN_W  = (R + 1 > 17) ? R + 1 : 17;
    localparam int Q_W    = DVN_W + 2;

    t_bstate r_state, n_state;

    logic [R-1:0]              r_mem [TABLE_DEPTH];
    logic [R-1:0]              r_rdata;
    logic [SEG_W-1:0]          w_raddr;
    logic                      w_mem_we;
    logic [SEG_W-1:0]          w_waddr;
    logic [31:0]               w_idx32;
    logic                      w_store;
    logic                      w_hit;
    logic                      w_last;

    logic [R-1:0]              r_rd;
    logic                      r_err;
    logic [SEG_W-1:0]          r_cnt;
    logic [SEG_W-1:0]          r_seg;
    logic [SEG_W-1:0]          w_segm1;
    logic [R-1:0]              r_x1;
    logic signed [R:0]         r_num;
    logic signed [R:0]         r_den;
    logic signed [PROD_W-1:0]  r_p1;
    logic signed [PROD_W-1:0]  r_p2;
    logic [SEG_W+15:0]         r_base;
    logic signed [Q_W-1:0]     r_q1;
    logic signed [Q_W-1:0]     r_q2;
    logic signed [Q_W-1:0]     r_q3;
    logic signed [15:0]        r_dist;
    logic [15:0]               r_cur;
    logic signed [31:0]        r_pnum;
    logic signed [16:0]        r_span;

    logic signed [Q_W:0]       w_dsum;
    logic signed [Q_W:0]       w_csum;
    logic signed [Q_W:0]       w_lo;
    logic signed [Q_W:0]       w_hi;
    logic [15:0]               w_cur;
    logic signed [15:0]        w_dist;
    logic [13:0]               w_per;
    logic [31:0]               w_seg32;

    logic                      w_div_start;
    logic signed [DVN_W-1:0]   w_div_num;
    logic signed [DEN_W-1:0]   w_div_den;
    logic                      w_div_done;
    logic signed [Q_W-1:0]     w_div_quo;
    logic                      w_out_load;
    logic                      r_out_valid;

    assign w_store = i_item[ITEM_W-1];
    assign w_idx32 = 32'(i_item[R+3:R]);
    assign w_waddr = w_idx32[SEG_W-1:0];
    assign w_hit   = (r_rdata <= r_rd);
    assign w_last  = (r_cnt == SEG_W'(TABLE_DEPTH - 2));
    assign w_segm1 = r_seg - 1'b1;

    csl_div #(.NUM_W(DVN_W), .DEN_W(DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (!i_empty && !w_store) n_state = S_SREQ;
            S_SREQ:  n_state = S_SCMP;
            S_SCMP:  n_state = (w_hit || w_last) ? S_X1 : S_SREQ;
            S_X1:    n_state = S_X2;
            S_X2:    n_state = S_DIFF;
            S_DIFF:  n_state = S_PROD;
            S_PROD:  n_state = S_DIST;
            S_DIST:  n_state = (r_den == '0) ? S_CURQ : S_DISTW;
            S_DISTW: if (w_div_done) n_state = S_CURQ;
            S_CURQ:  n_state = (r_den == '0) ? S_CLAMP : S_CURW;
            S_CURW:  if (w_div_done) n_state = S_CLAMP;
            S_CLAMP: n_state = S_PMUL;
            S_PMUL:  n_state = S_PER;
            S_PER:   n_state = (r_span == '0) ? S_OUT : S_PERW;
            S_PERW:  if (w_div_done) n_state = S_OUT;
            S_OUT:   if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        w_mem_we    = 1'b0;
        w_raddr     = r_cnt;
        w_div_start = 1'b0;
        w_div_num   = DVN_W'(r_p1);
        w_div_den   = DEN_W'(r_den);
        w_out_load  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_pop    = !i_empty;
                w_mem_we = !i_empty && w_store && (w_idx32 < 32'(TABLE_DEPTH));
            end
            S_X1: w_raddr = w_segm1;
            S_X2: w_raddr = r_seg;
            S_DIST: w_div_start = (r_den != '0);
            S_CURQ: begin
                w_div_start = (r_den != '0);
                w_div_num   = DVN_W'(r_p2);
            end
            S_PER: begin
                w_div_start = (r_span != '0);
                w_div_num   = DVN_W'(r_pnum);
                w_div_den   = DEN_W'(r_span);
            end
            S_OUT: w_out_load = !r_out_valid || !i_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_waddr] <= i_item[R-1:0];
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign w_dsum = (Q_W+1)'(r_q1) + (Q_W+1)'($signed({1'b0, w_segm1, 8'b0}));
    assign w_csum = (Q_W+1)'(r_q2) + (Q_W+1)'($signed({1'b0, r_base}))
                  + (Q_W+1)'($signed({1'b0, i_cfg.min_ua}));
    assign w_lo   = (Q_W+1)'($signed({1'b0, i_cfg.min_ua}));
    assign w_hi   = (Q_W+1)'($signed({1'b0, i_cfg.max_ua}));

    always_comb begin
        if (w_dsum > (Q_W+1)'(32767)) begin
            w_dist = 16'sh7FFF;
        end else if (w_dsum < -(Q_W+1)'(32768)) begin
            w_dist = 16'sh8000;
        end else begin
            w_dist = w_dsum[15:0];
        end
        if (w_csum < w_lo) begin
            w_cur = i_cfg.min_ua;
        end else if (w_csum > w_hi) begin
            w_cur = i_cfg.max_ua;
        end else begin
            w_cur = w_csum[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_rd  <= i_item[R-1:0];
                r_err <= i_item[R+4];
                r_cnt <= '0;
                r_q1  <= '0;
                r_q2  <= '0;
                r_q3  <= '0;
            end
            S_SCMP: begin
                if (w_hit) begin
                    r_seg <= (r_cnt == '0) ? SEG_W'(1) : r_cnt;
                end else if (w_last) begin
                    r_seg <= SEG_W'(TABLE_DEPTH - 1);
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            S_X2: r_x1 <= r_rdata;
            S_DIFF: begin
                r_num <= $signed({1'b0, r_rd}) - $signed({1'b0, r_x1});
                r_den <= $signed({1'b0, r_rdata}) - $signed({1'b0, r_x1});
            end
            S_PROD: begin
                r_p1   <= PROD_W'(r_num) <<< 8;
                r_p2   <= PROD_W'(r_num) * PROD_W'($signed({1'b0, i_cfg.step_ua}));
                r_base <= i_cfg.step_ua * w_segm1;
            end
            S_DISTW: if (w_div_done) r_q1 <= w_div_quo;
            S_CURW:  if (w_div_done) r_q2 <= w_div_quo;
            S_CLAMP: begin
                r_dist <= w_dist;
                r_cur  <= w_cur;
            end
            S_PMUL: begin
                r_pnum <= 32'($signed({1'b0, r_cur}) - $signed({1'b0, i_cfg.min_ua}))
                        * 32'(FULL_SCALE_X100);
                r_span <= $signed({1'b0, i_cfg.max_ua}) - $signed({1'b0, i_cfg.min_ua});
            end
            S_PERW: if (w_div_done) r_q3 <= w_div_quo;
            default: ;
        endcase
    end

    always_comb begin
        if (r_q3 < '0) begin
            w_per = '0;
        end else if (r_q3 > Q_W'(FULL_SCALE_X100)) begin
            w_per = 14'(FULL_SCALE_X100);
        end else begin
            w_per = r_q3[13:0];
        end
    end

    assign w_seg32 = 32'(r_seg);

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            o_reading       <= r_rd;
            o_data_error    <= r_err;
            o_segment_index <= w_seg32[3:0];
            o_distance_q8   <= r_dist;
            o_current_ua    <= r_cur;
            o_percent_x100  <= w_per;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule
`default_nettype wire

// File: bench/csl_checker.sv
// ----------------------------------------------------------------------------
// Sensor linearizer checker
// Watches the input, output and register ports of the linearizer. It keeps
// its own copy of the calibration table, the last good reading and the
// current limits. For every conversion transfer it predicts the expected
// result and compares each output transfer field by field, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module csl_checker
    import csl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic               i_in_stall,
    input  wire logic               i_cmd,
    input  wire logic [31:0]        i_raw_word,
    input  wire logic [3:0]         i_cal_index,
    input  wire logic               i_out_valid,
    input  wire logic               i_stall,
    input  wire logic [19:0]        i_reading,
    input  wire logic               i_data_error,
    input  wire logic [3:0]         i_segment_index,
    input  wire logic signed [15:0] i_distance_q8,
    input  wire logic [15:0]        i_current_ua,
    input  wire logic [13:0]        i_percent_x100,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic [19:0]        reading;
        logic               data_error;
        logic [3:0]         segment_index;
        logic signed [15:0] distance_q8;
        logic [15:0]        current_ua;
        logic [13:0]        percent_x100;
    } t_lin_result;

    t_lin_result lin_results_q[$];
    logic [19:0] cal_pts[TABLE_DEPTH_DEF];
    logic [19:0] good_reading;
    t_cfg        limits;

    function automatic longint div_nearest(input longint n, input longint d);
        longint un;
        longint ud;
        longint q;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q  = (un + ud / 2) / ud;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic t_lin_result linearize(input logic err);
        t_lin_result res;
        int     seg;
        longint x1, x2, den, num, dst, cur, lo, hi, stp, per, span;
        seg = TABLE_DEPTH_DEF;
        for (int k = 0; k < TABLE_DEPTH_DEF; k++) begin
            if (seg == TABLE_DEPTH_DEF && cal_pts[k] <= good_reading) seg = k;
        end
        if (seg < 1) seg = 1;
        if (seg > TABLE_DEPTH_DEF - 1) seg = TABLE_DEPTH_DEF - 1;
        x1   = longint'(cal_pts[seg-1]);
        x2   = longint'(cal_pts[seg]);
        den  = x2 - x1;
        num  = longint'(good_reading) - x1;
        lo   = longint'(limits.min_ua);
        hi   = longint'(limits.max_ua);
        stp  = longint'(limits.step_ua);
        dst  = longint'(seg - 1) * 256;
        cur  = lo + stp * longint'(seg - 1);
        if (den != 0) begin
            dst += div_nearest(num * 256, den);
            cur += div_nearest(num * stp, den);
        end
        if (dst > 32767) dst = 32767;
        if (dst < -32768) dst = -32768;
        if (cur < lo) cur = lo;
        else if (cur > hi) cur = hi;
        span = hi - lo;
        per  = (span == 0) ? 0 : div_nearest((cur - lo) * FULL_SCALE_X100, span);
        if (per < 0) per = 0;
        if (per > FULL_SCALE_X100) per = FULL_SCALE_X100;
        res.reading       = good_reading;
        res.data_error    = err;
        res.segment_index = seg[3:0];
        res.distance_q8   = dst[15:0];
        res.current_ua    = cur[15:0];
        res.percent_x100  = per[13:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_lin_result want;
        logic        err;
        if (!i_rst_n) begin
            lin_results_q.delete();
            good_reading   = '0;
            limits.min_ua  = MIN_CURRENT_RST;
            limits.max_ua  = MAX_CURRENT_RST;
            limits.step_ua = STEP_CURRENT_RST;
            for (int k = 0; k < TABLE_DEPTH_DEF; k++) cal_pts[k] = '0;
            o_fail_count   = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_CURRENT:  limits.min_ua  = i_cfg_data;
                    CFG_MAX_CURRENT:  limits.max_ua  = i_cfg_data;
                    CFG_STEP_CURRENT: limits.step_ua = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_stall) begin
                if (lin_results_q.size() == 0) begin
                    $error("result transfer with no expected result");
                    o_fail_count++;
                end else begin
                    want = lin_results_q.pop_front();
                    if (i_reading !== want.reading) begin
                        $error("reading exp %0h got %0h", want.reading, i_reading);
                        o_fail_count++;
                    end
                    if (i_data_error !== want.data_error) begin
                        $error("data_error exp %0b got %0b", want.data_error, i_data_error);
                        o_fail_count++;
                    end
                    if (i_segment_index !== want.segment_index) begin
                        $error("segment_index exp %0d got %0d",
                               want.segment_index, i_segment_index);
                        o_fail_count++;
                    end
                    if (i_distance_q8 !== want.distance_q8) begin
                        $error("distance_q8 exp %0d got %0d", want.distance_q8, i_distance_q8);
                        o_fail_count++;
                    end
                    if (i_current_ua !== want.current_ua) begin
                        $error("current_ua exp %0d got %0d", want.current_ua, i_current_ua);
                        o_fail_count++;
                    end
                    if (i_percent_x100 !== want.percent_x100) begin
                        $error("percent_x100 exp %0d got %0d",
                               want.percent_x100, i_percent_x100);
                        o_fail_count++;
                    end
                end
            end
            if (i_valid && !i_in_stall) begin
                if (i_cmd == CMD_STORE) begin
                    cal_pts[i_cal_index] = good_reading;
                end else begin
                    err = |i_raw_word[31:28];
                    if (!err) good_reading = i_raw_word[27:8];
                    lin_results_q.push_back(linearize(err));
                end
            end
        end
        o_pending = lin_results_q.size();
    end

endmodule
`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Sensor linearizer testbench
// Drives conversion and store transfers in random bursts while the receiver
// stalls on its own pattern, including one long hold-off. Each phase sets
// the current limits, rebuilds a descending calibration table and then sends
// conversion words near the table points or random, error words and stores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import csl_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_cmd;
    logic [31:0]        i_raw_word;
    logic [3:0]         i_cal_index;
    logic               o_valid;
    logic               i_stall;
    logic [19:0]        o_reading;
    logic               o_data_error;
    logic [3:0]         o_segment_index;
    logic signed [15:0] o_distance_q8;
    logic [15:0]        o_current_ua;
    logic [13:0]        o_percent_x100;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;
    int                 fail_count;
    int                 pending;

    logic [19:0] pts[TABLE_DEPTH_DEF];
    logic [19:0] held;
    int          burst_left;

    calibrated_sensor_linearizer dut (.*);

    csl_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in_stall(o_stall),
        .i_cmd(i_cmd), .i_raw_word(i_raw_word), .i_cal_index(i_cal_index),
        .i_out_valid(o_valid), .i_stall(i_stall), .i_reading(o_reading),
        .i_data_error(o_data_error), .i_segment_index(o_segment_index),
        .i_distance_q8(o_distance_q8), .i_current_ua(o_current_ua),
        .i_percent_x100(o_percent_x100), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

    // receiver: unstalled at first, then one long hold-off, then stretches of varying stall density
    initial begin
        int mode;
        i_stall <= 1'b0;
        repeat (200) @(posedge i_clk);
        i_stall <= 1'b1;
        repeat (2500) @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(1, 64)) begin
                @(posedge i_clk);
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= 1'($urandom_range(0, 1));
                    default: i_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic send(input logic cmd, input logic [31:0] word, input logic [3:0] idx);
        logic taken;
        i_valid     <= 1'b1;
        i_cmd       <= cmd;
        i_raw_word  <= word;
        i_cal_index <= idx;
        forever begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
            if (taken) break;
        end
        if (cmd == CMD_STORE) pts[idx] = held;
        else if (word[31:28] == 4'h0) held = word[27:8];
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            burst_left = $urandom_range(0, 40);
        end else begin
            burst_left--;
        end
    endtask

    task automatic convert(input logic [19:0] r);
        send(CMD_PROCESS, {4'h0, r, 8'($urandom_range(0, 255))}, 4'($urandom()));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic build_table();
        int v;
        int dt;
        v = $urandom_range(20'h80000, 20'hFFFFF);
        for (int k = 0; k < TABLE_DEPTH_DEF; k++) begin
            convert(20'(v));
            send(CMD_STORE, $urandom(), 4'(k));
            case ($urandom_range(0, 7))
                0:       dt = 0;
                1:       dt = $urandom_range(1, 16);
                default: dt = $urandom_range(1000, 65535);
            endcase
            v = (v > dt) ? v - dt : 0;
        end
    endtask

    task automatic run_phase(input logic [15:0] lo, input logic [15:0] hi,
                             input logic [15:0] stp, input int count);
        int sel;
        int r;
        drain();
        cfg_write(CFG_MIN_CURRENT, lo);
        cfg_write(CFG_MAX_CURRENT, hi);
        cfg_write(CFG_STEP_CURRENT, stp);
        cfg_write(CFG_UNUSED, 16'($urandom()));
        build_table();
        repeat (count) begin
            sel = $urandom_range(0, 99);
            if (sel < 60) begin
                r = int'(pts[$urandom_range(0, TABLE_DEPTH_DEF - 1)])
                    + $urandom_range(0, 8000) - 4000;
                if (r < 0) r = 0;
                if (r > 20'hFFFFF) r = 20'hFFFFF;
                convert(20'(r));
            end else if (sel < 80) begin
                convert(20'($urandom()));
            end else if (sel < 90) begin
                send(CMD_PROCESS, {4'($urandom_range(1, 15)), 28'($urandom())},
                     4'($urandom()));
            end else if (sel < 95) begin
                send(CMD_STORE, $urandom(), 4'($urandom()));
            end else begin
                convert(($urandom_range(0, 1) == 1) ? 20'hFFFFF : 20'h00000);
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_cmd       <= CMD_PROCESS;
        i_raw_word  <= '0;
        i_cal_index <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_MIN_CURRENT;
        i_cfg_data  <= '0;
        burst_left  = 0;
        held        = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole table with the reset reading before any lookup
        for (int k = 0; k < TABLE_DEPTH_DEF; k++) send(CMD_STORE, $urandom(), 4'(k));
        convert(20'h00000);
        convert(20'hFFFFF);
        build_table();
        convert(20'hFFFFF);
        convert(20'h00000);
        convert(pts[0]);
        convert(pts[TABLE_DEPTH_DEF - 1]);
        for (int b = 28; b < 32; b++) send(CMD_PROCESS, 32'h1 << b, 4'h0);
        send(CMD_PROCESS, 32'hFFFF_FFFF, 4'hF);
        send(CMD_STORE, 32'hFFFF_FFFF, 4'hF);
        convert(pts[7]);

        run_phase(MIN_CURRENT_RST, MAX_CURRENT_RST, STEP_CURRENT_RST, 240);
        run_phase(16'd0, 16'hFFFF, 16'hFFFF, 240);
        run_phase(16'hFFFF, 16'd0, 16'd0, 240);
        run_phase(16'd1000, 16'd1000, 16'd500, 240);
        run_phase(16'($urandom()), 16'($urandom()), 16'($urandom()), 240);
        drain();

        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
